@@ rtl/phit_pkg.sv @@
// shared types and codes for the point-in-shape hit test
// no dependencies; imported by every module of the block
`default_nettype none

package phit_pkg;

    // shape kind register codes
    typedef enum logic [1:0] {
        KIND_TRIANGLE = 2'd0,
        KIND_RECT     = 2'd1,
        KIND_LINE     = 2'd2,
        KIND_INVALID  = 2'd3
    } t_kind;

    // result codes
    localparam int STATUS_W = 2;
    typedef enum logic [STATUS_W-1:0] {
        STATUS_HIT      = 2'd0,
        STATUS_MISS     = 2'd1,
        STATUS_BAD_KIND = 2'd2
    } t_status;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_KIND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C_Y = 3'd6;

    // result beat width, status padded to a byte
    localparam int OUT_TDATA_W = 8;

    // number of products formed per beat
    localparam int PROD_N = 10;

    // control that rides along with each beat
    typedef struct packed {
        t_kind kind;
        logic  in_box;
    } t_ctl;

endpackage

`default_nettype wire

@@ rtl/phit_front.sv @@
// stages 1 and 2: coordinate differences, box test, then all products
// depends on phit_pkg
`default_nettype none

module phit_front #(
    parameter int CB = 12
) (
    input  wire logic                 i_clk,
    input  wire logic [1:0]           i_en,      // [0] stage 1, [1] stage 2
    input  wire logic [CB-1:0]        i_px,
    input  wire logic [CB-1:0]        i_py,
    input  wire phit_pkg::t_kind      i_kind,
    input  wire logic [CB-1:0]        i_ax,
    input  wire logic [CB-1:0]        i_ay,
    input  wire logic [CB-1:0]        i_bx,
    input  wire logic [CB-1:0]        i_by,
    input  wire logic [CB-1:0]        i_cx,
    input  wire logic [CB-1:0]        i_cy,
    output logic signed [2*CB:0]      o_prod [phit_pkg::PROD_N],
    output phit_pkg::t_ctl            o_ctl
);
    import phit_pkg::*;

    localparam int DW = CB + 1;
    localparam int PW = 2 * CB + 1;

    function automatic logic signed [PW-1:0] smul(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        logic signed [2*DW-1:0] f;
        f = a * b;
        return f[PW-1:0];
    endfunction

    // stage 1 registers
    logic signed [DW-1:0] r_dxa, r_dya, r_dxb, r_dyb, r_dxc, r_dyc;
    logic signed [DW-1:0] r_eabx, r_eaby, r_eacx, r_eacy;
    t_ctl                 r_ctl1;

    logic signed [DW-1:0] n_dxa, n_dya, n_dxb, n_dyb, n_dxc, n_dyc;
    logic signed [DW-1:0] n_eabx, n_eaby, n_eacx, n_eacy;
    t_ctl                 n_ctl1;
    logic [CB-1:0]        lox, hix, loy, hiy;

    always_comb begin
        n_dxa  = $signed({1'b0, i_px}) - $signed({1'b0, i_ax});
        n_dya  = $signed({1'b0, i_py}) - $signed({1'b0, i_ay});
        n_dxb  = $signed({1'b0, i_bx}) - $signed({1'b0, i_px});
        n_dyb  = $signed({1'b0, i_by}) - $signed({1'b0, i_py});
        n_dxc  = $signed({1'b0, i_cx}) - $signed({1'b0, i_px});
        n_dyc  = $signed({1'b0, i_cy}) - $signed({1'b0, i_py});
        n_eabx = $signed({1'b0, i_bx}) - $signed({1'b0, i_ax});
        n_eaby = $signed({1'b0, i_by}) - $signed({1'b0, i_ay});
        n_eacx = $signed({1'b0, i_cx}) - $signed({1'b0, i_ax});
        n_eacy = $signed({1'b0, i_cy}) - $signed({1'b0, i_ay});
        lox = (i_ax < i_bx) ? i_ax : i_bx;
        hix = (i_ax < i_bx) ? i_bx : i_ax;
        loy = (i_ay < i_by) ? i_ay : i_by;
        hiy = (i_ay < i_by) ? i_by : i_ay;
        n_ctl1.kind   = i_kind;
        n_ctl1.in_box = (i_px > lox) && (i_px < hix) && (i_py > loy) && (i_py < hiy);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_dxa  <= n_dxa;
            r_dya  <= n_dya;
            r_dxb  <= n_dxb;
            r_dyb  <= n_dyb;
            r_dxc  <= n_dxc;
            r_dyc  <= n_dyc;
            r_eabx <= n_eabx;
            r_eaby <= n_eaby;
            r_eacx <= n_eacx;
            r_eacy <= n_eacy;
            r_ctl1 <= n_ctl1;
        end
    end

    // stage 2: pairs for each doubled area, then squares of the line edge
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            o_prod[0] <= smul(r_eabx, r_eacy);   // full triangle
            o_prod[1] <= smul(r_eaby, r_eacx);
            o_prod[2] <= smul(r_dxb, r_dyc);     // point with b, c
            o_prod[3] <= smul(r_dyb, r_dxc);
            o_prod[4] <= smul(r_dxa, r_eacy);    // a with point, c
            o_prod[5] <= smul(r_dya, r_eacx);
            o_prod[6] <= smul(r_eabx, r_dya);    // a, b with point; also line numerator
            o_prod[7] <= smul(r_eaby, r_dxa);
            o_prod[8] <= smul(r_eaby, r_eaby);   // a^2
            o_prod[9] <= smul(r_eabx, r_eabx);   // b^2
            o_ctl     <= r_ctl1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/phit_area.sv @@
// stage 3: doubled areas with magnitudes, and the line distance limit
// depends on phit_pkg
`default_nettype none

module phit_area #(
    parameter int CB = 12
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [2*CB:0] i_prod [phit_pkg::PROD_N],
    input  wire phit_pkg::t_ctl       i_ctl,
    output logic [2*CB:0]             o_mag_s,
    output logic [2*CB:0]             o_mag1,
    output logic [2*CB:0]             o_mag2,
    output logic [2*CB:0]             o_mag3,
    output logic [2*CB+5:0]           o_lim,
    output phit_pkg::t_ctl            o_ctl
);
    import phit_pkg::*;

    localparam int PW = 2 * CB + 1;
    localparam int AW = 2 * CB + 2;
    localparam int MW = 2 * CB + 1;
    localparam int LW = 2 * CB + 6;

    function automatic logic [MW-1:0] mag_of(input logic signed [PW-1:0] p,
                                             input logic signed [PW-1:0] q);
        logic signed [AW-1:0] d;
        logic signed [AW-1:0] m;
        d = AW'(p) - AW'(q);
        m = d[AW-1] ? -d : d;
        return m[MW-1:0];
    endfunction

    logic [2*CB:0]   sq_sum;
    logic [LW-1:0]   sq_ext;

    always_comb begin
        sq_sum = {1'b0, i_prod[8][2*CB-1:0]} + {1'b0, i_prod[9][2*CB-1:0]};
        sq_ext = {{(LW-2*CB-1){1'b0}}, sq_sum};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mag_s <= mag_of(i_prod[0], i_prod[1]);
            o_mag1  <= mag_of(i_prod[2], i_prod[3]);
            o_mag2  <= mag_of(i_prod[4], i_prod[5]);
            o_mag3  <= mag_of(i_prod[6], i_prod[7]);
            // radius 5 squared is 16 + 8 + 1
            o_lim   <= (sq_ext << 4) + (sq_ext << 3) + sq_ext;
            o_ctl   <= i_ctl;
        end
    end

endmodule

`default_nettype wire

@@ rtl/phit_judge.sv @@
// stages 4 and 5: area sum compare, numerator square, then the status code
// depends on phit_pkg
`default_nettype none

module phit_judge #(
    parameter int CB = 12
) (
    input  wire logic            i_clk,
    input  wire logic [1:0]      i_en,      // [0] stage 4, [1] stage 5
    input  wire logic [2*CB:0]   i_mag_s,
    input  wire logic [2*CB:0]   i_mag1,
    input  wire logic [2*CB:0]   i_mag2,
    input  wire logic [2*CB:0]   i_mag3,
    input  wire logic [2*CB+5:0] i_lim,
    input  wire phit_pkg::t_ctl  i_ctl,
    output phit_pkg::t_status    o_status
);
    import phit_pkg::*;

    localparam int MW = 2 * CB + 1;
    localparam int SW = 2 * CB + 3;
    localparam int NB = CB + 3;       // any numerator at or above 2^NB is out of range
    localparam int LW = 2 * NB;

    logic [SW-1:0] area_sum;
    logic [NB-1:0] num;

    logic          r_tri_hit;
    logic          r_far;
    logic [LW-1:0] r_nsq;
    logic [LW-1:0] r_lim;
    t_ctl          r_ctl4;

    always_comb begin
        area_sum = SW'(i_mag1) + SW'(i_mag2) + SW'(i_mag3);
        num      = i_mag3[NB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_tri_hit <= (area_sum == SW'(i_mag_s));
            r_far     <= |i_mag3[MW-1:NB];
            r_nsq     <= LW'(num) * LW'(num);
            r_lim     <= i_lim;
            r_ctl4    <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            case (r_ctl4.kind)
                KIND_TRIANGLE: o_status <= r_tri_hit ? STATUS_HIT : STATUS_MISS;
                KIND_RECT:     o_status <= r_ctl4.in_box ? STATUS_HIT : STATUS_MISS;
                KIND_LINE: begin
                    o_status <= (r_ctl4.in_box && !r_far && (r_nsq <= r_lim))
                                ? STATUS_HIT : STATUS_MISS;
                end
                default:       o_status <= STATUS_BAD_KIND;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/point_in_shape_hit_test.sv @@
// top level of the point-in-shape hit test: config registers, beat control, stages
// depends on phit_pkg, phit_front, phit_area, phit_judge
//
//  channel   dir  handshake               payload (lowest bit first)
//  s (point) in   i_s_tvalid/o_s_tready   i_s_tdata: point_x, point_y, zero pad to bytes
//  m (result)out  o_m_tvalid/i_m_tready   o_m_tdata: hit_status, zero pad to 8 bits
//  cfg       in   i_cfg_we                i_cfg_idx, i_cfg_data (COORD_BITS wide)
//
// five register stages from an accepted beat to the result register; one beat per cycle
// sustained while the output is ready; the depth is set by the two multiply stages
// and the square of the line numerator
// reset (synchronous, active low) empties the pipe and clears all config registers to 0
// each stage holds only while it is full and the stage after it holds, so bubbles
// close up under a stall and input keeps flowing until all five stages are full
`default_nettype none

module point_in_shape_hit_test #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    // point stream
    input  wire logic                                    i_s_tvalid,
    output logic                                         o_s_tready,
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]       i_s_tdata,   // point_x, point_y
    // result stream
    output logic                                         o_m_tvalid,
    input  wire logic                                    i_m_tready,
    output logic [phit_pkg::OUT_TDATA_W-1:0]             o_m_tdata,   // hit_status
    // config write port
    input  wire logic                                    i_cfg_we,
    input  wire logic [phit_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [COORD_BITS-1:0]                   i_cfg_data
);
    import phit_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int NSTG = 5;

    // config registers
    t_kind         r_shape_kind;
    logic [CB-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_kind <= KIND_TRIANGLE;
            r_ax <= '0;
            r_ay <= '0;
            r_bx <= '0;
            r_by <= '0;
            r_cx <= '0;
            r_cy <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SHAPE_KIND: r_shape_kind <= t_kind'(i_cfg_data[1:0]);
                REG_VERTEX_A_X: r_ax <= i_cfg_data;
                REG_VERTEX_A_Y: r_ay <= i_cfg_data;
                REG_VERTEX_B_X: r_bx <= i_cfg_data;
                REG_VERTEX_B_Y: r_by <= i_cfg_data;
                REG_VERTEX_C_X: r_cx <= i_cfg_data;
                REG_VERTEX_C_Y: r_cy <= i_cfg_data;
                default: ;   // unused index, write dropped
            endcase
        end
    end

    // valid bits per stage, stage NSTG is the result register
    logic [NSTG:1]   r_vld;
    logic [NSTG+1:1] stage_en;

    always_comb begin
        stage_en[NSTG+1] = i_m_tready;
        for (int k = NSTG; k >= 1; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[1]) r_vld[1] <= i_s_tvalid;
            for (int k = 2; k <= NSTG; k++) begin
                if (stage_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_s_tready = stage_en[1];
    assign o_m_tvalid = r_vld[NSTG];

    // datapath
    logic signed [2*CB:0] prod [PROD_N];
    t_ctl                 ctl2, ctl3;
    logic [2*CB:0]        mag_s, mag1, mag2, mag3;
    logic [2*CB+5:0]      lim;
    t_status              status;

    phit_front #(.CB(CB)) u_front (
        .i_clk  (i_clk),
        .i_en   (stage_en[2:1]),
        .i_px   (i_s_tdata[CB-1:0]),
        .i_py   (i_s_tdata[2*CB-1:CB]),
        .i_kind (r_shape_kind),
        .i_ax   (r_ax),
        .i_ay   (r_ay),
        .i_bx   (r_bx),
        .i_by   (r_by),
        .i_cx   (r_cx),
        .i_cy   (r_cy),
        .o_prod (prod),
        .o_ctl  (ctl2)
    );

    phit_area #(.CB(CB)) u_area (
        .i_clk   (i_clk),
        .i_en    (stage_en[3]),
        .i_prod  (prod),
        .i_ctl   (ctl2),
        .o_mag_s (mag_s),
        .o_mag1  (mag1),
        .o_mag2  (mag2),
        .o_mag3  (mag3),
        .o_lim   (lim),
        .o_ctl   (ctl3)
    );

    phit_judge #(.CB(CB)) u_judge (
        .i_clk    (i_clk),
        .i_en     (stage_en[5:4]),
        .i_mag_s  (mag_s),
        .i_mag1   (mag1),
        .i_mag2   (mag2),
        .i_mag3   (mag3),
        .i_lim    (lim),
        .i_ctl    (ctl3),
        .o_status (status)
    );

    assign o_m_tdata = {{(OUT_TDATA_W-STATUS_W){1'b0}}, status};

    // checks
    logic in_fire, out_fire;
    assign in_fire  = i_s_tvalid && o_s_tready;
    assign out_fire = o_m_tvalid && i_m_tready;

    // input only backs up when every stage is full and the output is held
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (&r_vld) && !i_m_tready)
        else $error("input stalled with a free stage");

    // a beat taken in without one leaving adds one to the occupancy
    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !out_fire |=> $countones(r_vld) == $past($countones(r_vld)) + 1)
        else $error("accepted beat lost in the pipe");

    // a beat leaving without one coming in removes exactly one
    a_drain_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && !in_fire |=> $countones(r_vld) + 1 == $past($countones(r_vld)))
        else $error("result beat repeated or dropped");

endmodule

`default_nettype wire
